[hw/rtl/elephant_flow_marker_defines.svh]
// Assertion macros of the elephant flow marker checker.
`ifndef ELEPHANT_FLOW_MARKER_DEFINES_SVH
`define ELEPHANT_FLOW_MARKER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define EFM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow marker check failed");

// Check that cons holds in the cycle after ante.
`define EFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow marker check failed");

`endif

[hw/rtl/efm_pkg.sv]
// Shared types, constants and control structs of the elephant flow marker.
`timescale 1ns / 1ps
`default_nettype none

package efm_pkg;

    // Flow table geometry; BUCKETS must be a power of two.
    localparam int BUCKETS = 128;
    localparam int WAYS    = 4;
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
    localparam logic [7:0]  MARK_TOS_RESET  = 8'd192;

    // Register index taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MARK_TOS  = 1'b1;

    typedef enum logic [2:0] {
        STAT_UNTRACKED = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_FLUSHED   = 3'd4
    } flow_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_FLUSH,
        ST_RESPOND
    } ctrl_state_t;

    // One way of a bucket row
    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [39:0] ports;
        logic [31:0] total;
        logic        marked;
    } flow_entry_t;

    typedef flow_entry_t [WAYS-1:0] flow_row_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;
        logic             match;
        logic             update;
        logic             respond;
        logic             clear_en;
        logic [IDX_W-1:0] clear_idx;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_flush;
        logic in_tracked;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/elephant_flow_marker.sv]
// Top level of the elephant flow marker: register port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Elephant flow marker. Each TCP or UDP packet beat with distinct addresses is
// looked up in a 128-bucket by 4-way flow table and its byte count is raised,
// saturating; a new flow takes the lowest free way, and a full bucket reports
// table full. The first packet that pushes a flow past byte_threshold (APB
// offset 0x0) leaves with tos_out = mark_tos_value (offset 0x4). A tracked
// packet goes through row read, way compare, then update and write of the
// bucket row before its result is registered and the next beat is taken; the
// single read-modify-write of the bucket row sets this pace. Other packets go
// from accept straight to the respond step. A flush beat clears the table one
// row per cycle, then answers. After reset the same clearing pass runs before
// the first beat is accepted. While out_ready blocks the result register, the
// update and respond steps wait. A new beat is accepted while the previous
// result still waits on out_ready.
module elephant_flow_marker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Packet channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] sport,
    input  wire logic [15:0] dport,
    input  wire logic [7:0]  protocol,
    input  wire logic [15:0] packet_length,
    input  wire logic [7:0]  tos_in,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             mark,
    output logic [7:0]       tos_out,
    output logic [31:0]      flow_bytes,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import efm_pkg::*;

    logic [31:0] threshold_reg;
    logic [7:0]  mark_tos_reg;
    logic        reg_wr;
    ctrl_cmd_t   cmd;
    dp_status_t  st;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            mark_tos_reg  <= MARK_TOS_RESET;
        end
        else if (reg_wr)
        begin
            unique case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata;
                REG_MARK_TOS:  mark_tos_reg  <= pwdata[7:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = threshold_reg;
            REG_MARK_TOS:  prdata = {24'b0, mark_tos_reg};
            default:       prdata = '0;
        endcase
    end

    efm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    efm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .operation      (operation),
        .src_ip         (src_ip),
        .dst_ip         (dst_ip),
        .sport          (sport),
        .dport          (dport),
        .protocol       (protocol),
        .packet_length  (packet_length),
        .tos_in         (tos_in),
        .byte_threshold (threshold_reg),
        .mark_tos_value (mark_tos_reg),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .mark           (mark),
        .tos_out        (tos_out),
        .flow_bytes     (flow_bytes)
    );

endmodule

`default_nettype wire

[hw/rtl/efm_ctrl.sv]
// Controller state machine: clearing sweeps, packet sequencing, result handoff.
`timescale 1ns / 1ps
`default_nettype none

module efm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire efm_pkg::dp_status_t st,
    output efm_pkg::ctrl_cmd_t      cmd
);
    import efm_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_last;

    assign clr_last = (clr_cnt_reg == IDX_W'(BUCKETS - 1));

    // State and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd           = '0;
        cmd.clear_idx = clr_cnt_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every row after reset
                cmd.clear_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    if (st.in_flush)
                        state_next = ST_FLUSH;
                    else if (st.in_tracked)
                        state_next = ST_MATCH;
                    else
                        state_next = ST_RESPOND;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Hold until the output register is free
                if (!st.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                cmd.clear_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                if (!st.out_busy)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/efm_datapath.sv]
// Datapath: item capture, flow table memory, way match, count update, result register.
`timescale 1ns / 1ps
`default_nettype none

module efm_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire efm_pkg::ctrl_cmd_t  cmd,
    output efm_pkg::dp_status_t      st,
    input  wire logic                operation,
    input  wire logic [31:0]         src_ip,
    input  wire logic [31:0]         dst_ip,
    input  wire logic [15:0]         sport,
    input  wire logic [15:0]         dport,
    input  wire logic [7:0]          protocol,
    input  wire logic [15:0]         packet_length,
    input  wire logic [7:0]          tos_in,
    input  wire logic [31:0]         byte_threshold,
    input  wire logic [7:0]          mark_tos_value,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [2:0]               status,
    output logic                     mark,
    output logic [7:0]               tos_out,
    output logic [31:0]              flow_bytes
);
    import efm_pkg::*;

    // Flow table: one row per bucket
    flow_row_t    mem [BUCKETS];
    flow_row_t    rd_row_reg;
    flow_row_t    wr_row;
    logic         wr_en;
    logic [IDX_W-1:0] wr_addr;

    // Captured item
    logic             flush_reg;
    logic [63:0]      addrs_reg;
    logic [39:0]      ports_reg;
    logic [15:0]      len_reg;
    logic [7:0]       tos_reg;
    logic [IDX_W-1:0] bucket_reg;
    logic [IDX_W-1:0] bucket_now;
    logic [31:0]      hash_sum;

    // Match results
    logic             found_reg;
    logic             has_free_reg;
    logic [WAY_W-1:0] sel_way_reg;
    logic [31:0]      sel_total_reg;
    logic             sel_marked_reg;
    logic             found_c;
    logic             has_free_c;
    logic [WAY_W-1:0] hit_way_c;
    logic [WAY_W-1:0] free_way_c;

    // Update
    logic [32:0]      sum_c;
    logic [31:0]      total_c;
    logic             marked_old_c;
    logic             full_c;
    logic             mark_c;
    flow_status_t     upd_status_c;

    // Result register
    logic             out_valid_reg;
    flow_status_t     out_status_reg;
    logic             out_mark_reg;
    logic [7:0]       out_tos_reg;
    logic [31:0]      out_bytes_reg;

    // Classify the offered item and hash it; only the low index bits of the sum matter
    assign hash_sum   = src_ip + dst_ip + {16'b0, sport} + {16'b0, dport}
                      + {24'b0, protocol};
    assign bucket_now = hash_sum[IDX_W-1:0];

    assign st.in_flush   = operation;
    assign st.in_tracked = (src_ip != dst_ip) && ((protocol == PROTO_TCP)
                           || (protocol == PROTO_UDP));
    assign st.out_busy   = out_valid_reg && !out_ready;

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            flush_reg  <= operation;
            addrs_reg  <= {src_ip, dst_ip};
            ports_reg  <= {sport, dport, protocol};
            len_reg    <= packet_length;
            tos_reg    <= tos_in;
            bucket_reg <= bucket_now;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (cmd.capture)
            rd_row_reg <= mem[bucket_now];
    end

    // Find the first matching way and the first free way
    always_comb
    begin
        found_c    = 1'b0;
        has_free_c = 1'b0;
        hit_way_c  = '0;
        free_way_c = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].valid)
            begin
                if ((rd_row_reg[w].addrs == addrs_reg) && (rd_row_reg[w].ports == ports_reg))
                begin
                    found_c   = 1'b1;
                    hit_way_c = WAY_W'(w);
                end
            end
            else
            begin
                has_free_c = 1'b1;
                free_way_c = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            found_reg      <= found_c;
            has_free_reg   <= has_free_c;
            sel_way_reg    <= found_c ? hit_way_c : free_way_c;
            sel_total_reg  <= rd_row_reg[hit_way_c].total;
            sel_marked_reg <= rd_row_reg[hit_way_c].marked;
        end
    end

    // Saturating count update and threshold check
    always_comb
    begin
        sum_c        = {1'b0, sel_total_reg} + {17'b0, len_reg};
        total_c      = found_reg ? (sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0])
                                 : {16'b0, len_reg};
        marked_old_c = found_reg && sel_marked_reg;
        full_c       = !found_reg && !has_free_reg;
        mark_c       = !full_c && (total_c > byte_threshold) && !marked_old_c;
        if (found_reg)
            upd_status_c = STAT_UPDATED;
        else if (has_free_reg)
            upd_status_c = STAT_INSERTED;
        else
            upd_status_c = STAT_FULL;
    end

    // Row write: clear sweep or flow update
    always_comb
    begin
        wr_row  = rd_row_reg;
        wr_addr = bucket_reg;
        wr_en   = 1'b0;
        if (cmd.clear_en)
        begin
            wr_row  = '0;
            wr_addr = cmd.clear_idx;
            wr_en   = 1'b1;
        end
        else if (cmd.update && !full_c)
        begin
            wr_row[sel_way_reg].valid  = 1'b1;
            wr_row[sel_way_reg].addrs  = addrs_reg;
            wr_row[sel_way_reg].ports  = ports_reg;
            wr_row[sel_way_reg].total  = total_c;
            wr_row[sel_way_reg].marked = marked_old_c || mark_c;
            wr_en = 1'b1;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.update || cmd.respond)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_status_reg <= upd_status_c;
            out_mark_reg   <= mark_c;
            out_tos_reg    <= mark_c ? mark_tos_value : tos_reg;
            out_bytes_reg  <= full_c ? 32'd0 : total_c;
        end
        else if (cmd.respond)
        begin
            out_status_reg <= flush_reg ? STAT_FLUSHED : STAT_UNTRACKED;
            out_mark_reg   <= 1'b0;
            out_tos_reg    <= tos_reg;
            out_bytes_reg  <= 32'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign mark       = out_mark_reg;
    assign tos_out    = out_tos_reg;
    assign flow_bytes = out_bytes_reg;

endmodule

`default_nettype wire

[hw/rtl/efm_checker.sv]
// Port-level checker of the elephant flow marker and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "elephant_flow_marker_defines.svh"

module efm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic        mark,
    input wire logic [31:0] flow_bytes
);
    import efm_pkg::*;

    // A stalled result beat holds its status
    `EFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

    // One packet at a time: no accept right after an accept
    `EFM_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // Only a tracked flow can be marked
    `EFM_ASSERT_NOW(a_mark_tracked, out_valid && mark,
        (status == STAT_UPDATED) || (status == STAT_INSERTED))

    // Untracked, full and flush results carry no byte count
    `EFM_ASSERT_NOW(a_no_bytes, out_valid && ((status == STAT_UNTRACKED)
        || (status == STAT_FULL) || (status == STAT_FLUSHED)), (flow_bytes == 32'd0) && !mark)

endmodule

bind elephant_flow_marker efm_checker u_efm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .mark       (mark),
    .flow_bytes (flow_bytes)
);

`default_nettype wire

[dv/elephant_flow_marker_tb.sv]
// Self-checking testbench for the elephant flow marker: directed and random packet beats.
`timescale 1ns / 1ps

module elephant_flow_marker_tb;
    import efm_pkg::*;

    localparam int ENTRIES       = BUCKETS * WAYS;
    localparam bit OP_PACKET     = 1'b0;
    localparam bit OP_FLUSH      = 1'b1;
    localparam int IDLE_PCT      = 11;
    localparam int CALM_FROM     = 300;
    localparam int CALM_TO       = 500;
    localparam int STALL_AT      = 180;
    localparam int STALL_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BEATS  = 100;
    localparam int POOL_FLOWS    = 16;
    localparam int SHARED_FLOWS  = 6;
    localparam int BIG_PACKETS   = 40;
    localparam int CYCLE_LIMIT   = 200_000;

    typedef struct {
        bit        op;
        bit [31:0] sip;
        bit [31:0] dip;
        bit [15:0] sp;
        bit [15:0] dp;
        bit [7:0]  proto;
        bit [15:0] len;
        bit [7:0]  tos;
    } packet_beat_t;

    typedef struct {
        flow_status_t status;
        bit           mark;
        bit [7:0]     tos;
        bit [31:0]    bytes;
    } flow_verdict_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        operation     = 1'b0;
    logic [31:0] src_ip        = '0;
    logic [31:0] dst_ip        = '0;
    logic [15:0] sport         = '0;
    logic [15:0] dport         = '0;
    logic [7:0]  protocol      = '0;
    logic [15:0] packet_length = '0;
    logic [7:0]  tos_in        = '0;
    logic        out_ready     = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic        mark;
    logic [7:0]  tos_out;
    logic [31:0] flow_bytes;
    logic [31:0] prdata;
    logic        pready;

    // Flow table shadow and register copies
    bit        tbl_valid [ENTRIES];
    bit [63:0] tbl_addrs [ENTRIES];
    bit [39:0] tbl_ports [ENTRIES];
    bit [31:0] tbl_total [ENTRIES];
    bit        tbl_marked [ENTRIES];
    bit [31:0] mark_threshold = THRESHOLD_RESET;
    bit [7:0]  mark_tos       = MARK_TOS_RESET;

    packet_beat_t  pending_beats[$];
    flow_verdict_t predicted[$];
    packet_beat_t  offered;
    int            beats_issued = 0;
    int            beats_taken  = 0;
    int            results_seen = 0;
    int            failures     = 0;
    int            stall_left   = 0;
    bit            stall_done   = 1'b0;
    int            cycle_count  = 0;

    elephant_flow_marker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .src_ip       (src_ip),
        .dst_ip       (dst_ip),
        .sport        (sport),
        .dport        (dport),
        .protocol     (protocol),
        .packet_length(packet_length),
        .tos_in       (tos_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .mark         (mark),
        .tos_out      (tos_out),
        .flow_bytes   (flow_bytes),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Look up, update or insert the flow and work out the packet's verdict
    function automatic flow_verdict_t track_packet(input packet_beat_t p);
        flow_verdict_t v;
        bit [63:0]     addrs;
        bit [39:0]     ports;
        bit [31:0]     sum;
        bit [32:0]     grown;
        int            base;
        int            slot;
        int            free_slot;
        bit            found;
        bit            has_free;
        v.status  = STAT_UNTRACKED;
        v.mark    = 1'b0;
        v.tos     = p.tos;
        v.bytes   = '0;
        found     = 1'b0;
        has_free  = 1'b0;
        slot      = 0;
        free_slot = 0;
        if (p.op == OP_FLUSH)
        begin
            foreach (tbl_valid[i])
                tbl_valid[i] = 1'b0;
            v.status = STAT_FLUSHED;
        end
        else if (p.sip != p.dip && (p.proto == PROTO_TCP || p.proto == PROTO_UDP))
        begin
            addrs = {p.sip, p.dip};
            ports = {p.sp, p.dp, p.proto};
            sum   = p.sip + p.dip + 32'(p.sp) + 32'(p.dp) + 32'(p.proto);
            base  = int'(sum % 32'(BUCKETS)) * WAYS;
            // Scan the bucket: first matching way, lowest free way
            for (int w = 0; w < WAYS; w++)
            begin
                if (tbl_valid[base + w])
                begin
                    if (!found && tbl_addrs[base + w] == addrs && tbl_ports[base + w] == ports)
                    begin
                        found = 1'b1;
                        slot  = base + w;
                    end
                end
                else if (!has_free)
                begin
                    has_free  = 1'b1;
                    free_slot = base + w;
                end
            end
            if (found)
            begin
                grown           = {1'b0, tbl_total[slot]} + 33'(p.len);
                tbl_total[slot] = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
                v.status        = STAT_UPDATED;
            end
            else if (has_free)
            begin
                slot             = free_slot;
                tbl_valid[slot]  = 1'b1;
                tbl_addrs[slot]  = addrs;
                tbl_ports[slot]  = ports;
                tbl_total[slot]  = 32'(p.len);
                tbl_marked[slot] = 1'b0;
                v.status         = STAT_INSERTED;
            end
            else
                v.status = STAT_FULL;
            // Mark only the first packet that pushes the flow past the threshold
            if (v.status != STAT_FULL)
            begin
                v.bytes = tbl_total[slot];
                if (v.bytes > mark_threshold && !tbl_marked[slot])
                begin
                    tbl_marked[slot] = 1'b1;
                    v.mark           = 1'b1;
                    v.tos            = mark_tos;
                end
            end
        end
        return v;
    endfunction

    function automatic void offer_packet(input bit op, input bit [31:0] sip, input bit [31:0] dip,
                                         input bit [15:0] sp, input bit [15:0] dp,
                                         input bit [7:0] proto, input bit [15:0] len,
                                         input bit [7:0] tos);
        packet_beat_t b;
        b.op    = op;
        b.sip   = sip;
        b.dip   = dip;
        b.sp    = sp;
        b.dp    = dp;
        b.proto = proto;
        b.len   = len;
        b.tos   = tos;
        pending_beats.push_back(b);
    endfunction

    // Wait until every queued beat is in and every verdict is out, then let the block go quiet
    task automatic settle();
        while (pending_beats.size() != 0 || beats_issued != beats_taken || predicted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD)
            mark_threshold = value;
        else
            mark_tos = value[7:0];
    endtask

    // Set the registers, then queue mostly pool flows with some noise and flushes
    task automatic random_phase(input logic [31:0] thr, input logic [31:0] tos_val);
        packet_beat_t pool[POOL_FLOWS];
        packet_beat_t b;
        bit [31:0]    shared_dip;
        int           counted;
        int           roll;
        bit           clash;
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MARK_TOS, tos_val);
        // Build a group that lands in one bucket: sip steps by the bucket count
        pool[0].op    = OP_PACKET;
        pool[0].sip   = $urandom;
        pool[0].sp    = 16'($urandom);
        pool[0].dp    = 16'($urandom);
        pool[0].proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        for (int k = 1; k < SHARED_FLOWS; k++)
        begin
            pool[k]     = pool[0];
            pool[k].sip = pool[0].sip + 32'(k * BUCKETS);
        end
        do
        begin
            shared_dip = $urandom;
            clash      = 1'b0;
            for (int k = 0; k < SHARED_FLOWS; k++)
                if (pool[k].sip == shared_dip)
                    clash = 1'b1;
        end
        while (clash);
        for (int k = 0; k < SHARED_FLOWS; k++)
            pool[k].dip = shared_dip;
        for (int k = SHARED_FLOWS; k < POOL_FLOWS; k++)
        begin
            pool[k].op    = OP_PACKET;
            pool[k].sip   = $urandom;
            pool[k].sp    = 16'($urandom);
            pool[k].dp    = 16'($urandom);
            pool[k].proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            do
                pool[k].dip = $urandom;
            while (pool[k].dip == pool[k].sip);
        end
        counted = 0;
        while (counted < RANDOM_BEATS)
        begin
            roll    = $urandom_range(0, 99);
            b.op    = OP_PACKET;
            b.sip   = $urandom;
            b.dip   = $urandom;
            b.sp    = 16'($urandom);
            b.dp    = 16'($urandom);
            b.proto = 8'($urandom_range(0, 255));
            b.len   = 16'($urandom);
            b.tos   = 8'($urandom);
            if (roll < 2)
            begin
                b.op = OP_FLUSH;
                counted++;
            end
            else if (roll < 4)
            begin
                b.dip   = b.sip;
                b.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            end
            else if (roll >= 7)
            begin
                b     = pool[$urandom_range(0, POOL_FLOWS - 1)];
                b.len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
                b.tos = 8'($urandom);
                counted++;
            end
            pending_beats.push_back(b);
        end
        settle();
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Packet driver: predict each accepted beat, then offer the next one or idle
    always @(posedge clk)
    begin
        bit open_slot;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            open_slot = !in_valid || in_ready;
            if (in_valid && in_ready)
            begin
                predicted.push_back(track_packet(offered));
                beats_taken++;
            end
            if (open_slot)
            begin
                if (pending_beats.size() != 0 &&
                    !((beats_taken < CALM_FROM || beats_taken >= CALM_TO) &&
                      $urandom_range(0, 99) < IDLE_PCT))
                begin
                    offered = pending_beats.pop_front();
                    beats_issued++;
                    operation     <= offered.op;
                    src_ip        <= offered.sip;
                    dst_ip        <= offered.dip;
                    sport         <= offered.sp;
                    dport         <= offered.dp;
                    protocol      <= offered.proto;
                    packet_length <= offered.len;
                    tos_in        <= offered.tos;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each beat against the oldest verdict, then pick out_ready
    always @(posedge clk)
    begin
        flow_verdict_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted.size() == 0)
                begin
                    failures++;
                    $error("result beat with nothing predicted: status %0d flow_bytes %0d",
                           status, flow_bytes);
                end
                else
                begin
                    want = predicted.pop_front();
                    if (status !== want.status)
                    begin
                        failures++;
                        $error("status: expected %0d, got %0d", want.status, status);
                    end
                    if (mark !== want.mark)
                    begin
                        failures++;
                        $error("mark: expected %0d, got %0d", want.mark, mark);
                    end
                    if (tos_out !== want.tos)
                    begin
                        failures++;
                        $error("tos_out: expected 0x%02h, got 0x%02h", want.tos, tos_out);
                    end
                    if (flow_bytes !== want.bytes)
                    begin
                        failures++;
                        $error("flow_bytes: expected %0d, got %0d", want.bytes, flow_bytes);
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up into its input
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!stall_done && results_seen >= STALL_AT)
            begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                             $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial
    begin
        bit [7:0] sat_tos;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: extremes, untracked cases, threshold edge, full bucket
        offer_packet(OP_PACKET, '0, '0, '0, '0, '0, '0, '0);
        offer_packet(OP_PACKET, '1, '1, '1, '1, '1, '1, '1);
        offer_packet(OP_FLUSH, '1, '1, '1, '1, '1, '1, '1);
        offer_packet(OP_PACKET, 32'h0A00_0005, 32'h0A00_0005, 443, 443, PROTO_TCP, 100, 8'h11);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_TCP, 600, 8'h01);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_TCP, 400, 8'h02);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_TCP, 1, 8'h03);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_TCP, '1, 8'h04);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_UDP, '1, 8'h05);
        for (int k = 0; k < WAYS + 1; k++)
            offer_packet(OP_PACKET, 32'hC0A8_0010 + 32'(k * BUCKETS), 32'hC0A8_00FE, 5000, 5001,
                         PROTO_TCP, 200, 8'(k));
        offer_packet(OP_PACKET, 32'hC0A8_0010 + 32'(2 * BUCKETS), 32'hC0A8_00FE, 5000, 5001,
                     PROTO_TCP, 1000, 8'h20);
        offer_packet(OP_PACKET, 32'hC0A8_0010 + 32'(WAYS * BUCKETS), 32'hC0A8_00FE, 5000, 5001,
                     PROTO_TCP, 50, 8'h21);
        offer_packet(OP_FLUSH, '0, '0, '0, '0, '0, '0, '0);
        offer_packet(OP_PACKET, 32'hC0A8_0010 + 32'(WAYS * BUCKETS), 32'hC0A8_00FE, 5000, 5001,
                     PROTO_TCP, 50, 8'h22);
        offer_packet(OP_PACKET, 32'h0A00_0001, 32'h0A00_0002, 1234, 80, PROTO_TCP, 10, 8'h23);
        offer_packet(OP_PACKET, '1, '0, '1, '1, PROTO_TCP, '1, '1);
        settle();

        // Zero threshold: a zero-length insert stays unmarked, any growth marks
        write_reg(REG_THRESHOLD, 32'h0);
        write_reg(REG_MARK_TOS, 32'h0);
        offer_packet(OP_PACKET, 32'h1111_0001, 32'h2222_0002, 7, 9, PROTO_UDP, 0, 8'hA5);
        offer_packet(OP_PACKET, 32'h1111_0001, 32'h2222_0002, 7, 9, PROTO_UDP, 1, 8'hA6);
        settle();
        write_reg(REG_MARK_TOS, 32'hFF);
        offer_packet(OP_PACKET, 32'h3333_0003, 32'h4444_0004, 21, 22, PROTO_TCP, 0, 8'h3C);
        offer_packet(OP_PACKET, 32'h3333_0003, 32'h4444_0004, 21, 22, PROTO_TCP, 2, 8'h3D);
        offer_packet(OP_PACKET, 32'h1111_0001, 32'h2222_0002, 7, 9, PROTO_UDP, 5, 8'hA7);
        settle();

        random_phase(32'($urandom_range(0, 3000)), 32'($urandom_range(0, 255)));
        random_phase(32'hFFFF_FFFF, 32'hFF);
        random_phase(32'h0, 32'h0);
        random_phase($urandom, 32'($urandom_range(0, 255)));
        random_phase(THRESHOLD_RESET, 32'(MARK_TOS_RESET));

        // Drive one flow to large totals: the 33rd full-size packet crosses the threshold
        write_reg(REG_THRESHOLD, 32'h0020_0000);
        write_reg(REG_MARK_TOS, 32'h5A);
        offer_packet(OP_FLUSH, '0, '0, '0, '0, '0, '0, '0);
        for (int n = 0; n < BIG_PACKETS; n++)
        begin
            sat_tos = 8'($urandom);
            offer_packet(OP_PACKET, 32'h0808_0808, 32'h0101_0101, 53, 53000, PROTO_UDP, '1,
                         sat_tos);
        end
        settle();

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/efm_pkg.sv
hw/rtl/efm_ctrl.sv
hw/rtl/efm_datapath.sv
hw/rtl/elephant_flow_marker.sv
hw/rtl/efm_checker.sv
dv/elephant_flow_marker_tb.sv
